>>> hw/rtl/efb_pkg.sv
package efb_pkg;

   // Default cap on the number of gap bytes after the CRC.
   localparam int MAX_GAP_DEF = 32;

   // Register widths and reset values.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam logic [63:0] PREAMBLE_RST = 64'd18110129059318257109;
   localparam logic [47:0] DEST_MAC_RST = 48'd0;
   localparam logic [47:0] SRC_MAC_RST = 48'd0;
   localparam logic [15:0] TYPE_LENGTH_RST = 16'd1500;
   localparam logic [5:0] MIN_GAP_RST = 6'd12;
   localparam logic [7:0] GAP_BYTE_RST = 8'd7;
   localparam logic [31:0] CRC_POLY_RST = 32'd79764919;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_TOP_BIT = 32'h8000_0000;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PREAMBLE = 3'd0,
      REG_DEST_MAC = 3'd1,
      REG_SRC_MAC = 3'd2,
      REG_TYPE_LENGTH = 3'd3,
      REG_MIN_GAP = 3'd4,
      REG_GAP_BYTE = 3'd5,
      REG_CRC_POLY = 3'd6
   } reg_index_type;

   // Kind codes carried with every output byte.
   typedef enum logic [2:0] {
      KIND_PREAMBLE = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_CRC = 3'd3,
      KIND_GAP = 3'd4
   } kind_type;

   // Program steps of the sequencer.
   typedef enum logic [2:0] {
      S_PRE = 3'd0,
      S_DST = 3'd1,
      S_SRC = 3'd2,
      S_TL = 3'd3,
      S_PAY = 3'd4,
      S_CRC = 3'd5,
      S_GAP = 3'd6,
      S_PAD = 3'd7
   } step_type;

   // Byte source of a step.
   typedef enum logic [2:0] {
      SEL_PRE,
      SEL_DST,
      SEL_SRC,
      SEL_TL,
      SEL_DATA,
      SEL_CRC,
      SEL_GAP
   } sel_type;

   // How the byte count of a step is found.
   typedef enum logic [1:0] {
      LEN_CONST,
      LEN_GAP,
      LEN_PAD
   } len_type;

   // What follows the last byte of a step.
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_IF_LAST,
      JMP_END
   } jump_type;

   // One control word of the program.
   typedef struct packed {
      sel_type sel;
      kind_type kind;
      len_type len_mode;
      logic [3:0] len;
      logic crc_en;
      jump_type jump;
      step_type next;
   } ctl_type;

   // The program: one control word per step.
   function automatic ctl_type ucode(step_type s);
      ctl_type c;
      case (s)
         S_PRE: c = '{SEL_PRE, KIND_PREAMBLE, LEN_CONST, 4'd8, 1'b0, JMP_NEXT, S_DST};
         S_DST: c = '{SEL_DST, KIND_HEADER, LEN_CONST, 4'd6, 1'b1, JMP_NEXT, S_SRC};
         S_SRC: c = '{SEL_SRC, KIND_HEADER, LEN_CONST, 4'd6, 1'b1, JMP_NEXT, S_TL};
         S_TL: c = '{SEL_TL, KIND_HEADER, LEN_CONST, 4'd2, 1'b1, JMP_NEXT, S_PAY};
         S_PAY: c = '{SEL_DATA, KIND_PAYLOAD, LEN_CONST, 4'd1, 1'b1, JMP_IF_LAST, S_CRC};
         S_CRC: c = '{SEL_CRC, KIND_CRC, LEN_CONST, 4'd4, 1'b0, JMP_NEXT, S_GAP};
         S_GAP: c = '{SEL_GAP, KIND_GAP, LEN_GAP, 4'd0, 1'b0, JMP_NEXT, S_PAD};
         S_PAD: c = '{SEL_GAP, KIND_GAP, LEN_PAD, 4'd0, 1'b0, JMP_END, S_PRE};
         default: c = '{SEL_GAP, KIND_GAP, LEN_CONST, 4'd0, 1'b0, JMP_END, S_PRE};
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/ethernet_frame_builder_top.sv
// Channel   Direction  Beat contents
// req_*     in         tdata[7:0] payload byte, tlast = last payload byte of frame
// rsp_*     out        tdata[7:0] framed byte, tuser[2:0] kind, tuser[3] end of run,
//                      tlast = final byte of the padded frame
// csr_*     in         write enable, register index, write data (no read-back)
//
// A payload byte inside a frame is taken as the one before it is sent, so payload flows
// at one byte per cycle while the output is not stalled.
// The first byte of a frame follows the preamble and header; the last is followed by
// the CRC, the gap and the pad bytes. Each byte passes through a single output register.
// Reset is synchronous and returns the configuration, control state and CRC to their defaults.
// A stalled result stops the sequencer; the input is taken again when the run ends.
module ethernet_frame_builder_top
   import efb_pkg::*;
#(
   parameter int MAX_GAP = MAX_GAP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Payload input.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // data_byte
   input  logic                   req_tlast,
   // Framed output.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // out_byte
   output logic [3:0]             rsp_tuser,   // kind [2:0], end_of_run [3]
   output logic                   rsp_tlast,
   // Configuration writes.
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // The byte counter holds the longest step length less one.
   localparam int LONGEST = (MAX_GAP > 8) ? MAX_GAP : 8;
   localparam int CW = $clog2(LONGEST + 1);

   // Configuration registers.
   logic [63:0] pre_ff;
   logic [47:0] dst_ff;
   logic [47:0] src_ff;
   logic [15:0] tl_ff;
   logic [5:0]  min_gap_ff;
   logic [7:0]  gap_ff;
   logic [31:0] poly_ff;

   // Sequencer and frame state.
   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          in_frame_ff, in_frame_in;
   logic [31:0]   crc_ff, crc_in;
   logic [1:0]    mod_ff, mod_in;
   logic [7:0]    data_ff, data_in;
   logic          last_ff, last_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   logic       rsp_eor_ff, rsp_eor_in;
   logic       rsp_eof_ff, rsp_eof_in;

   // Decode and control.
   ctl_type       ctl, ctl1, ctl2;
   step_type      nxt, start;
   logic [CW-1:0] gap_len;
   logic [1:0]    pad_len;
   logic          last_byte, done, eor, eof, emit, accept;
   logic [7:0]    byte_val;
   logic [31:0]   crc_fin;

   // One byte through the CRC, MSB first.
   function automatic logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b, logic [31:0] p);
      logic [31:0] r;
      r = c ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_TOP_BIT) != 32'd0) begin
            r = {r[30:0], 1'b0} ^ p;
         end else begin
            r = {r[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Byte count of a step.
   function automatic logic [CW-1:0] len_of(ctl_type c, logic [CW-1:0] g, logic [1:0] pd);
      logic [CW-1:0] l;
      case (c.len_mode)
         LEN_CONST: l = CW'(c.len);
         LEN_GAP: l = g;
         LEN_PAD: l = CW'(pd);
         default: l = '0;
      endcase
      return l;
   endfunction

   // Configuration writes; bits beyond a register's width are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= PREAMBLE_RST;
         dst_ff <= DEST_MAC_RST;
         src_ff <= SRC_MAC_RST;
         tl_ff <= TYPE_LENGTH_RST;
         min_gap_ff <= MIN_GAP_RST;
         gap_ff <= GAP_BYTE_RST;
         poly_ff <= CRC_POLY_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PREAMBLE: pre_ff <= csr_wr_data;
            REG_DEST_MAC: dst_ff <= csr_wr_data[47:0];
            REG_SRC_MAC: src_ff <= csr_wr_data[47:0];
            REG_TYPE_LENGTH: tl_ff <= csr_wr_data[15:0];
            REG_MIN_GAP: min_gap_ff <= csr_wr_data[5:0];
            REG_GAP_BYTE: gap_ff <= csr_wr_data[7:0];
            REG_CRC_POLY: poly_ff <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   // Gap count capped at the limit; pad count fills to a multiple of four after this byte.
   assign gap_len = ({1'b0, min_gap_ff} > 7'(MAX_GAP)) ? CW'(MAX_GAP) : CW'(min_gap_ff);
   assign pad_len = ~mod_ff;
   assign crc_fin = ~crc_ff;

   // Byte source selection.
   always_comb begin
      ctl = ucode(step_ff);
      case (ctl.sel)
         SEL_PRE: byte_val = pre_ff[8*cnt_ff[2:0] +: 8];
         SEL_DST: byte_val = dst_ff[8*cnt_ff[2:0] +: 8];
         SEL_SRC: byte_val = src_ff[8*cnt_ff[2:0] +: 8];
         SEL_TL: byte_val = tl_ff[8*cnt_ff[0] +: 8];
         SEL_DATA: byte_val = data_ff;
         SEL_CRC: byte_val = crc_fin[8*cnt_ff[1:0] +: 8];
         default: byte_val = gap_ff;
      endcase
   end

   // Jump resolution: empty gap and pad steps are passed over.
   always_comb begin
      nxt = ctl.next;
      done = 1'b0;
      ctl1 = ucode(ctl.next);
      ctl2 = ucode(ctl1.next);
      if (ctl.jump == JMP_END || (ctl.jump == JMP_IF_LAST && !last_ff)) begin
         done = 1'b1;
      end else if (len_of(ctl1, gap_len, pad_len) == '0) begin
         if (ctl1.jump == JMP_END || len_of(ctl2, gap_len, pad_len) == '0) begin
            done = 1'b1;
         end else begin
            nxt = ctl1.next;
         end
      end
   end

   assign last_byte = (cnt_ff == '0);
   assign eor = last_byte && done;
   assign eof = eor && (ctl.jump != JMP_IF_LAST);
   assign emit = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || (emit && eor);
   assign accept = req_tvalid && req_tready;
   assign start = (in_frame_ff && !eof) ? S_PAY : S_PRE;

   // Next state of the sequencer, the frame state and the output register.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      in_frame_in = in_frame_ff;
      crc_in = crc_ff;
      mod_in = mod_ff;
      data_in = data_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in = rsp_byte_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_eor_in = rsp_eor_ff;
      rsp_eof_in = rsp_eof_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = byte_val;
         rsp_kind_in = ctl.kind;
         rsp_eor_in = eor;
         rsp_eof_in = eof;
         mod_in = mod_ff + 2'd1;
         if (ctl.crc_en) begin
            crc_in = crc_feed(crc_ff, byte_val, poly_ff);
         end
         if (!last_byte) begin
            cnt_in = cnt_ff - CW'(1);
         end else if (done) begin
            busy_in = 1'b0;
         end else begin
            step_in = nxt;
            cnt_in = len_of(ucode(nxt), gap_len, pad_len) - CW'(1);
         end
         if (eof) begin
            crc_in = CRC_INIT;
            in_frame_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         step_in = start;
         cnt_in = len_of(ucode(start), gap_len, pad_len) - CW'(1);
         data_in = req_tdata;
         last_in = req_tlast;
         in_frame_in = 1'b1;
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= S_PRE;
         cnt_ff <= '0;
         in_frame_ff <= 1'b0;
         crc_ff <= CRC_INIT;
         mod_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         cnt_ff <= cnt_in;
         in_frame_ff <= in_frame_in;
         crc_ff <= crc_in;
         mod_ff <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_eor_ff <= rsp_eor_in;
      rsp_eof_ff <= rsp_eof_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_byte_ff;
   assign rsp_tuser = {rsp_eor_ff, rsp_kind_ff};
   assign rsp_tlast = rsp_eof_ff;

   // The end of a frame is always the end of a run.
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> rsp_eor_ff)
      else $error("frame end without run end");

   // A padded frame ends on a four-byte boundary.
   a_eof_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> mod_ff == 2'd0)
      else $error("frame length not a multiple of four");

   // The CRC is back at its initial value once a frame has ended.
   a_eof_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> crc_ff == CRC_INIT)
      else $error("CRC not restored after frame end");

   // No input is taken during the preamble and header, nor before the last CRC byte.
   a_no_take_mid: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff == S_PRE || step_ff == S_DST || step_ff == S_SRC ||
                  step_ff == S_TL || (step_ff == S_CRC && cnt_ff != '0)) |-> !req_tready)
      else $error("input taken during header or trailer");

   // A stalled result holds its byte while the sequencer waits.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && busy_ff |=> $stable(rsp_byte_ff) && $stable(step_ff))
      else $error("result changed during stall");

endmodule

>>> tb/frame_byte_checker.sv
// Watches the payload, framed-byte and register channels of the frame builder.
// It predicts every framed byte from the accepted payload beats and compares each
// accepted output beat with the oldest prediction.
module frame_byte_checker
   import efb_pkg::*;
#(
   parameter int MAX_GAP = MAX_GAP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,
   input  logic [3:0]             rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     fail_count,
   output int                     bytes_due
);

   typedef struct packed {
      logic [7:0] value;
      kind_type   kind;
      logic       run_end;
      logic       frame_end;
   } framed_byte_type;

   // Framed bytes still owed by the block, oldest first.
   framed_byte_type bytes_due_q[$];

   // Shadow copy of the registers.
   logic [63:0] preamble;
   logic [47:0] dest_mac;
   logic [47:0] src_mac;
   logic [15:0] type_len;
   logic [5:0]  min_gap;
   logic [7:0]  gap_value;
   logic [31:0] poly;

   // Shadow copy of the framing state.
   logic        in_frame;
   logic [31:0] crc;
   logic [1:0]  len_mod4;

   int report_count = 0;

   // Folds one byte into the running CRC, most significant bit first.
   function automatic void crc_byte(input logic [7:0] b);
      crc = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         if (crc[31]) crc = (crc << 1) ^ poly;
         else crc = crc << 1;
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b, input kind_type k);
      framed_byte_type e;
      e.value = b;
      e.kind = k;
      e.run_end = 1'b0;
      e.frame_end = 1'b0;
      bytes_due_q.insert(bytes_due_q.size(), e);
      len_mod4 = len_mod4 + 2'd1;
   endfunction

   // Sends a multi-byte field most significant byte first.
   function automatic void push_field(input logic [63:0] v, input int nbytes,
                                      input kind_type k, input logic crc_on);
      logic [7:0] b;
      for (int i = nbytes - 1; i >= 0; i--) begin
         b = v[8*i +: 8];
         if (crc_on) crc_byte(b);
         push_byte(b, k);
      end
   endfunction

   // Works out every framed byte that one payload beat causes.
   function automatic void predict_frame_bytes(input logic [7:0] data, input logic last);
      int gaps;
      int tail;
      framed_byte_type e;
      if (!in_frame) begin
         crc = CRC_INIT;
         len_mod4 = 2'd0;
         push_field(preamble, 8, KIND_PREAMBLE, 1'b0);
         push_field({16'h0, dest_mac}, 6, KIND_HEADER, 1'b1);
         push_field({16'h0, src_mac}, 6, KIND_HEADER, 1'b1);
         push_field({48'h0, type_len}, 2, KIND_HEADER, 1'b1);
         in_frame = 1'b1;
      end
      crc_byte(data);
      push_byte(data, KIND_PAYLOAD);
      if (last) begin
         // The gap count saturates at the cap, then pad bytes align to four.
         gaps = (int'(min_gap) > MAX_GAP) ? MAX_GAP : int'(min_gap);
         push_field({32'h0, ~crc}, 4, KIND_CRC, 1'b0);
         for (int i = 0; i < gaps; i++) push_byte(gap_value, KIND_GAP);
         while (len_mod4 != 2'd0) push_byte(gap_value, KIND_GAP);
         tail = bytes_due_q.size() - 1;
         e = bytes_due_q[tail];
         e.frame_end = 1'b1;
         bytes_due_q[tail] = e;
         in_frame = 1'b0;
         crc = CRC_INIT;
         len_mod4 = 2'd0;
      end
      tail = bytes_due_q.size() - 1;
      e = bytes_due_q[tail];
      e.run_end = 1'b1;
      bytes_due_q[tail] = e;
   endfunction

   // Tracks register writes, predicts on payload beats and checks framed beats.
   always @(posedge clock) begin : watch_channels
      framed_byte_type due;
      if (reset) begin
         preamble = PREAMBLE_RST;
         dest_mac = DEST_MAC_RST;
         src_mac = SRC_MAC_RST;
         type_len = TYPE_LENGTH_RST;
         min_gap = MIN_GAP_RST;
         gap_value = GAP_BYTE_RST;
         poly = CRC_POLY_RST;
         in_frame = 1'b0;
         crc = CRC_INIT;
         len_mod4 = 2'd0;
         bytes_due_q.delete();
         fail_count <= 0;
      end else begin
         // Writes to an index beyond the register list are dropped.
         if (csr_wr_en) begin
            case (csr_index)
               REG_PREAMBLE: preamble = csr_wr_data;
               REG_DEST_MAC: dest_mac = csr_wr_data[47:0];
               REG_SRC_MAC: src_mac = csr_wr_data[47:0];
               REG_TYPE_LENGTH: type_len = csr_wr_data[15:0];
               REG_MIN_GAP: min_gap = csr_wr_data[5:0];
               REG_GAP_BYTE: gap_value = csr_wr_data[7:0];
               REG_CRC_POLY: poly = csr_wr_data[31:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) predict_frame_bytes(req_tdata, req_tlast);

         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (report_count < 50) begin
                  $display("%0t: no framed beat expected,", $time,
                           " got data %h kind %0d run_end %b frame_end %b",
                           rsp_tdata, rsp_tuser[2:0], rsp_tuser[3], rsp_tlast);
               end
               report_count++;
            end else begin
               due = bytes_due_q.pop_front();
               if (rsp_tdata !== due.value || rsp_tuser[2:0] !== due.kind ||
                   rsp_tuser[3] !== due.run_end || rsp_tlast !== due.frame_end) begin
                  fail_count <= fail_count + 1;
                  if (report_count < 50) begin
                     $display("%0t: framed beat expected data %h kind %0d", $time,
                              due.value, due.kind,
                              " run_end %b frame_end %b,", due.run_end, due.frame_end,
                              " got data %h kind %0d run_end %b frame_end %b",
                              rsp_tdata, rsp_tuser[2:0], rsp_tuser[3], rsp_tlast);
                  end
                  report_count++;
               end
            end
         end
      end
      bytes_due <= bytes_due_q.size();
   end

endmodule

>>> tb/tb_ethernet_frame_builder_top.sv
// Drives payload frames and register settings into the frame builder, with
// random idling on both channels, and reports the checker's verdict.
module tb_ethernet_frame_builder_top;
   import efb_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RUN_LIMIT = 12_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic [3:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int fail_count;
   int bytes_due;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   always #10 clock = ~clock;

   ethernet_frame_builder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   frame_byte_checker u_frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .bytes_due   (bytes_due)
   );

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Offers one payload beat, with random idle cycles ahead of it.
   task automatic send_payload_byte(input logic [7:0] d, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_frame(input int length);
      for (int i = 0; i < length; i++) send_payload_byte(8'($urandom), i == length - 1);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering beats and waits until every framed byte has come out.
   task automatic drain_frames();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct <= 0;
            recv_stall_pct <= 0;
         end
         1: begin
            send_idle_pct <= 45;
            recv_stall_pct <= 0;
         end
         2: begin
            send_idle_pct <= 0;
            recv_stall_pct <= 45;
         end
         default: begin
            send_idle_pct <= 32;
            recv_stall_pct <= 32;
         end
      endcase
   endtask

   // Random registers, upper bits too; gap mostly in range, poly often at its reset value.
   task automatic write_random_config();
      int r;
      r = $urandom_range(99);
      write_reg(REG_PREAMBLE, {$urandom, $urandom});
      write_reg(REG_DEST_MAC, {$urandom, $urandom});
      write_reg(REG_SRC_MAC, {$urandom, $urandom});
      write_reg(REG_TYPE_LENGTH, {$urandom, $urandom});
      if (r < 15) write_reg(REG_MIN_GAP, {$urandom, $urandom});
      else write_reg(REG_MIN_GAP, 64'($urandom_range(0, MAX_GAP_DEF)));
      write_reg(REG_GAP_BYTE, {$urandom, $urandom});
      if (r % 3 == 0) write_reg(REG_CRC_POLY, 64'(CRC_POLY_RST));
      else write_reg(REG_CRC_POLY, {$urandom, $urandom});
   endtask

   initial begin : stimulus
      int items;
      int pick;
      int length;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a single-byte frame, then a short one.
      send_payload_byte(8'h00, 1'b1);
      send_payload_byte(8'hFF, 1'b0);
      send_payload_byte(8'h80, 1'b0);
      send_payload_byte(8'h01, 1'b1);
      drain_frames();

      // All-ones registers but a zero type/length; the gap write is masked and then capped.
      write_reg(REG_PREAMBLE, '1);
      write_reg(REG_DEST_MAC, '1);
      write_reg(REG_SRC_MAC, '1);
      write_reg(REG_TYPE_LENGTH, 64'd0);
      write_reg(REG_MIN_GAP, '1);
      write_reg(REG_GAP_BYTE, '1);
      write_reg(REG_CRC_POLY, '1);
      write_reg(REG_UNMAPPED, {$urandom, $urandom});
      send_payload_byte(8'hFF, 1'b1);
      send_payload_byte(8'h00, 1'b0);
      send_payload_byte(8'h7F, 1'b0);
      send_payload_byte(8'hFE, 1'b1);
      drain_frames();

      // All-zero registers, with a type/length of 25.
      write_reg(REG_PREAMBLE, 64'd0);
      write_reg(REG_DEST_MAC, 64'd0);
      write_reg(REG_SRC_MAC, 64'd0);
      write_reg(REG_TYPE_LENGTH, 64'd25);
      write_reg(REG_MIN_GAP, 64'd0);
      write_reg(REG_GAP_BYTE, 64'd0);
      write_reg(REG_CRC_POLY, 64'd0);
      send_payload_byte(8'hAA, 1'b1);
      send_payload_byte(8'h55, 1'b0);
      send_payload_byte(8'hAA, 1'b0);
      send_payload_byte(8'h01, 1'b0);
      send_payload_byte(8'h02, 1'b1);
      drain_frames();

      // Gap just above the cap, then small gaps that change the pad length.
      write_reg(REG_MIN_GAP, 64'd33);
      write_reg(REG_GAP_BYTE, 64'h5A);
      write_reg(REG_CRC_POLY, 64'(CRC_POLY_RST));
      write_reg(REG_TYPE_LENGTH, 64'hFFFF);
      send_frame(5);
      drain_frames();
      write_reg(REG_MIN_GAP, 64'd1);
      send_frame(2);
      drain_frames();
      write_reg(REG_MIN_GAP, 64'd3);
      send_frame(1);
      drain_frames();

      // Random phases, each under its own settings and idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         write_random_config();
         set_idling(ph % 4);
         @(posedge clock);
         if (ph == 4) hold_requests <= hold_requests + 1;
         items = 0;
         while (items < 24) begin
            pick = $urandom_range(99);
            if (pick < 70) length = $urandom_range(1, 6);
            else if (pick < 92) length = $urandom_range(7, 20);
            else length = $urandom_range(21, 48);
            send_frame(length);
            items += length;
         end
         drain_frames();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/efb_pkg.sv
hw/rtl/ethernet_frame_builder_top.sv
tb/frame_byte_checker.sv
tb/tb_ethernet_frame_builder_top.sv
